/* hdl/dark_column_run_segmenter_assert.svh */
// Assertion macros for the dark column run segmenter.
`ifndef DARK_COLUMN_RUN_SEGMENTER_ASSERT_SVH
`define DARK_COLUMN_RUN_SEGMENTER_ASSERT_SVH

// Condition in one cycle implies a condition in the same cycle.
`define DCRS_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define DCRS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

/* hdl/dcrs_pkg.sv */
package dcrs_pkg;

  localparam int MAX_COLUMNS_DEF = 128;

  localparam int THR_W   = 10;
  localparam int FW_W    = 8;
  localparam int FH_W    = 13;
  localparam int ROW_W   = 12;
  localparam int START_W = 7;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [THR_W-1:0] THR_RESET = 10'd360;
  localparam logic [FW_W-1:0]  FW_RESET  = 8'd128;
  localparam logic [FH_W-1:0]  FH_RESET  = 13'd480;
  localparam logic [FH_W-1:0]  MAX_ROWS  = 13'd4096;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [FW_W-1:0]  width;
    logic [FH_W-1:0]  height;
  } cfg_t;

  typedef struct packed {
    logic set_all;
    logic shift;
  } cell_ctrl_t;

endpackage

/* hdl/dcrs_cell.sv */
module dcrs_cell
  import dcrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       clear_here,
  input  logic       right_flag,
  output logic       flag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b1;
    end else if (ctrl.shift) begin
      flag <= right_flag;
    end else if (clear_here) begin
      flag <= 1'b0;
    end else if (ctrl.set_all) begin
      flag <= 1'b1;
    end
  end

endmodule

/* hdl/dcrs_regs.sv */
module dcrs_regs
  import dcrs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THR_RESET;
      cfg.width     <= FW_RESET;
      cfg.height    <= FH_RESET;
    end else if (wr) begin
      case (idx)
        REG_THRESHOLD: cfg.threshold <= pwdata[THR_W-1:0];
        REG_WIDTH:     cfg.width     <= pwdata[FW_W-1:0];
        REG_HEIGHT:    cfg.height    <= pwdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = {{(DATA_W-THR_W){1'b0}}, cfg.threshold};
      REG_WIDTH:     prdata = {{(DATA_W-FW_W){1'b0}}, cfg.width};
      REG_HEIGHT:    prdata = {{(DATA_W-FH_W){1'b0}}, cfg.height};
      default:       prdata = '0;
    endcase
  end

endmodule

/* hdl/dark_column_run_segmenter.sv */
// Dark column run segmenter.
// Pixels of one frame enter in raster order on blue, green and red; a pixel
// is taken at a rising edge where start is high and busy is low. While a
// frame streams in, one pixel is taken every cycle. pready is always high.
// The threshold, width and height registers sit on the APB-style port and
// are to be written by the user only while the block is idle; the block
// itself does not enforce this. After the last pixel of the frame, busy
// stays high while the row of column cells shifts its light flags past the
// run detector, one column per cycle. Each run of dark columns is reported
// with result_valid high for one cycle; the last result of a frame has last
// set, and a frame without dark columns gives a single result with found low.
// The final result of a frame follows the scan of all its columns.
// Results cannot be stalled by the receiver.
// Reset restores the register defaults, clears the pixel counters and sets
// every column flag light.
module dark_column_run_segmenter
  import dcrs_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  input  logic [7:0]         blue,
  input  logic [7:0]         green,
  input  logic [7:0]         red,
  output logic               busy,
  output logic               result_valid,
  output logic               found,
  output logic [START_W-1:0] run_start,
  output logic [FW_W-1:0]    run_end,
  output logic               reaches_edge,
  output logic               last
);

  `include "dark_column_run_segmenter_assert.svh"

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam logic [FW_W-1:0] MAX_W = FW_W'(MAX_COLUMNS);

  cfg_t                   cfg;
  state_t                 state, state_next;
  logic [FW_W-1:0]        w;
  logic [FH_W-1:0]        h;
  logic                   accept;
  logic [THR_W-1:0]       sum;
  logic                   dark;
  logic [CW-1:0]          col;
  logic [ROW_W-1:0]       row;
  logic                   last_col, last_row, frame_start;
  logic [MAX_COLUMNS-1:0] flags, flags_right, clear_here;
  cell_ctrl_t             ctrl;

  logic [CW-1:0]   scan_col;
  logic            in_run, in_run_next;
  logic [CW-1:0]   run_first, run_first_next;
  logic            scan_last, scan_dark;
  logic            emit, emit_edge;
  logic [CW-1:0]   emit_start;
  logic [FW_W-1:0] emit_end;
  logic            pend_valid, pend_edge;
  logic [CW-1:0]   pend_start;
  logic [FW_W-1:0] pend_end;

  dcrs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign w = (cfg.width == '0) ? FW_W'(1) : ((cfg.width > MAX_W) ? MAX_W : cfg.width);
  assign h = (cfg.height == '0) ? FH_W'(1) : ((cfg.height > MAX_ROWS) ? MAX_ROWS : cfg.height);

  assign busy   = (state != ST_IDLE);
  assign accept = start & ~busy;
  assign sum    = {2'b00, blue} + {2'b00, green} + {2'b00, red};
  assign dark   = (sum < cfg.threshold);

  assign last_col    = ((FW_W'(col) + FW_W'(1)) >= w);
  assign last_row    = ((FH_W'(row) + FH_W'(1)) >= h);
  assign frame_start = (col == '0) && (row == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  assign ctrl.shift   = (state == ST_SCAN);
  assign ctrl.set_all = accept & frame_start;
  assign flags_right  = {1'b1, flags[MAX_COLUMNS-1:1]};

  for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_cell
    assign clear_here[k] = accept & dark & (col == CW'(k));
    dcrs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .clear_here (clear_here[k]),
      .right_flag (flags_right[k]),
      .flag       (flags[k])
    );
  end

  assign scan_dark = ~flags[0];
  assign scan_last = ((FW_W'(scan_col) + FW_W'(1)) >= w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    emit           = 1'b0;
    emit_edge      = 1'b0;
    emit_start     = run_first;
    emit_end       = FW_W'(scan_col);
    in_run_next    = in_run;
    run_first_next = run_first;
    case (state)
      ST_IDLE: begin
        if (accept && last_col && last_row) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_dark) begin
          in_run_next = 1'b1;
          if (!in_run) begin
            run_first_next = scan_col;
            emit_start     = scan_col;
          end
          if (scan_last) begin
            emit      = 1'b1;
            emit_end  = w;
            emit_edge = 1'b1;
          end
        end else begin
          in_run_next = 1'b0;
          emit        = in_run;
        end
        if (scan_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_col     <= '0;
      in_run       <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          scan_col   <= '0;
          in_run     <= 1'b0;
          pend_valid <= 1'b0;
        end
        ST_SCAN: begin
          scan_col  <= scan_col + CW'(1);
          in_run    <= in_run_next;
          run_first <= run_first_next;
          if (emit) begin
            if (pend_valid) begin
              result_valid <= 1'b1;
              found        <= 1'b1;
              run_start    <= START_W'(pend_start);
              run_end      <= pend_end;
              reaches_edge <= pend_edge;
              last         <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_start <= emit_start;
            pend_end   <= emit_end;
            pend_edge  <= emit_edge;
          end
        end
        ST_FLUSH: begin
          result_valid <= 1'b1;
          found        <= pend_valid;
          run_start    <= pend_valid ? START_W'(pend_start) : '0;
          run_end      <= pend_valid ? pend_end : '0;
          reaches_edge <= pend_valid & pend_edge;
          last         <= 1'b1;
          pend_valid   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  `DCRS_ASSERT_NEXT(a_result_only_after_scan, state == ST_IDLE, !result_valid, "result outside a frame scan")
  `DCRS_ASSERT_NEXT(a_flush_gives_last, state == ST_FLUSH, result_valid && last, "frame ended without a last result")
  `DCRS_ASSERT_NOW(a_empty_is_last, result_valid && !found, last, "empty result not marked last")
  `DCRS_ASSERT_NOW(a_run_not_empty, result_valid && found, run_end > FW_W'(run_start), "run end not past run start")

endmodule
